// ===== design/mq_pkg.sv =====
`timescale 1ns / 1ps

package mq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W  = 31;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN
  } ctrl_state_e;

  typedef struct packed {
    logic [VAL_W-1:0] popped_value;
    logic [VAL_W-1:0] max_value;
    logic             queue_empty;
    status_e          status;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] ptr);
    logic [ADDR_W-1:0] nxt;
    if (ptr == ADDR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

endpackage

// ===== design/mq_if.sv =====
`timescale 1ns / 1ps

interface mq_in_if;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [mq_pkg::VAL_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mq_out_if;
  logic                    valid;
  logic                    ready;
  logic [mq_pkg::VAL_W-1:0] popped_value;
  logic [mq_pkg::VAL_W-1:0] max_value;
  logic                    queue_empty;
  logic [1:0]              status;

  modport source (output valid, output popped_value, output max_value,
                  output queue_empty, output status, input ready);
  modport sink   (input valid, input popped_value, input max_value,
                  input queue_empty, input status, output ready);
endinterface

// ===== design/mq_ram.sv =====
`timescale 1ns / 1ps

module mq_ram #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 31,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/mq_ctrl.sv =====
`timescale 1ns / 1ps

module mq_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_op_i,
  input  logic [mq_pkg::VAL_W-1:0] in_value_i,
  output logic                     in_ready_o,
  input  logic                     out_free_i,
  output logic                     res_vld_o,
  output mq_pkg::res_t             res_o,
  output mq_pkg::mem_req_t         mem_req_o,
  input  logic [mq_pkg::VAL_W-1:0] mem_rdata_i
);
  import mq_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [ADDR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [VAL_W-1:0]  max_q, max_d;
  logic [ADDR_W-1:0] scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]  scan_left_q, scan_left_d;
  logic              pend_q, pend_d;
  logic [VAL_W-1:0]  best_q, best_d;
  logic [VAL_W-1:0]  popped_q, popped_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      max_q       <= '0;
      scan_left_q <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      max_q       <= max_d;
      scan_left_q <= scan_left_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    best_q     <= best_d;
    popped_q   <= popped_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    max_d       = max_q;
    scan_ptr_d  = scan_ptr_q;
    scan_left_d = scan_left_q;
    pend_d      = pend_q;
    best_d      = best_q;
    popped_d    = popped_q;
    in_ready_o  = 1'b0;
    res_vld_o   = 1'b0;
    res_o       = '{popped_value: '0, max_value: max_q,
                    queue_empty: (count_q == '0), status: ST_OK};
    mem_req_o   = '{we: 1'b0, waddr: tail_q, wdata: in_value_i,
                    re: 1'b0, raddr: head_q};

    case (state_q)
      S_IDLE: begin
        in_ready_o = out_free_i;
        if (in_valid_i && out_free_i) begin
          if (in_op_i == OP_PUSH) begin
            res_vld_o = 1'b1;
            if (count_q == CNT_W'(DEPTH)) begin
              res_o.status = ST_PUSH_FULL;
            end else begin
              mem_req_o.we = 1'b1;
              tail_d       = ptr_inc(tail_q);
              count_d      = count_q + 1'b1;
              if (in_value_i > max_q) begin
                max_d = in_value_i;
              end
              res_o.max_value   = max_d;
              res_o.queue_empty = 1'b0;
            end
          end else if (count_q == '0) begin
            res_vld_o    = 1'b1;
            res_o.status = ST_POP_EMPTY;
          end else begin
            // fetch the front word, decide next cycle
            mem_req_o.re = 1'b1;
            state_d      = S_POP;
          end
        end
      end

      S_POP: begin
        popped_d = mem_rdata_i;
        head_d   = ptr_inc(head_q);
        count_d  = count_q - 1'b1;
        res_o.popped_value = mem_rdata_i;
        if (count_q == CNT_W'(1)) begin
          max_d             = '0;
          res_vld_o         = 1'b1;
          res_o.max_value   = '0;
          res_o.queue_empty = 1'b1;
          state_d           = S_IDLE;
        end else if (mem_rdata_i == max_q) begin
          // max left the queue: rescan what remains
          scan_ptr_d  = ptr_inc(head_q);
          scan_left_d = count_q - 1'b1;
          best_d      = '0;
          pend_d      = 1'b0;
          state_d     = S_SCAN;
        end else begin
          res_vld_o         = 1'b1;
          res_o.queue_empty = 1'b0;
          state_d           = S_IDLE;
        end
      end

      S_SCAN: begin
        if (scan_left_q != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = scan_ptr_q;
          scan_ptr_d      = ptr_inc(scan_ptr_q);
          scan_left_d     = scan_left_q - 1'b1;
          pend_d          = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && (mem_rdata_i > best_q)) begin
          best_d = mem_rdata_i;
        end
        if ((scan_left_q == '0) && !pend_q) begin
          max_d              = best_q;
          res_vld_o          = 1'b1;
          res_o.popped_value = popped_q;
          res_o.max_value    = best_q;
          res_o.queue_empty  = 1'b0;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fifo_with_running_max.sv =====
`timescale 1ns / 1ps

// Bounded FIFO of 31-bit values that reports its running maximum.
// Input channel in_i carries one word per operation: operation 0 pushes
// value at the back, operation 1 pops the front. Output channel out_o
// returns one word per input word: popped value, maximum held afterwards,
// empty flag and status (pop on empty queue, or push dropped when full).
// Push and failed operations are decided in the idle state at acceptance and
// their result is registered in the output register. A pop reads the front
// entry from the entry RAM and is decided in the pop state; when it removes
// the maximum and entries remain, they are rescanned through the single RAM
// read port, one read per cycle, before the result is registered.
// One operation is in flight at a time; in_i.ready is high only while the
// controller is idle and the output register is empty or being drained.
// Reset clears head, tail, count and maximum; RAM contents are not cleared
// and are never read before being written.
// When out_o.ready stays low the result holds in the output register and
// no further input word is taken.
module fifo_with_running_max (
  input  logic  clk_i,
  input  logic  rst_ni,
  mq_in_if.sink    in_i,
  mq_out_if.source out_o
);
  import mq_pkg::*;

  logic             out_free;
  logic             res_vld;
  res_t             res;
  mem_req_t         mem_req;
  logic [VAL_W-1:0] mem_rdata;
  logic             out_vld_q, out_vld_d;
  res_t             out_res_q, out_res_d;

  assign out_free = !out_vld_q || out_o.ready;

  mq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_value_i  (in_i.value),
    .in_ready_o  (in_i.ready),
    .out_free_i  (out_free),
    .res_vld_o   (res_vld),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  mq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    out_res_d = out_res_q;
    if (res_vld) begin
      out_vld_d = 1'b1;
      out_res_d = res;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.popped_value = out_res_q.popped_value;
  assign out_o.max_value    = out_res_q.max_value;
  assign out_o.queue_empty  = out_res_q.queue_empty;
  assign out_o.status       = 2'(out_res_q.status);

endmodule

// ===== design/fifo_with_running_max_chk.sv =====
`timescale 1ns / 1ps

module mq_chk (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [mq_pkg::VAL_W-1:0] popped_value_i,
  input logic [mq_pkg::VAL_W-1:0] max_value_i,
  input logic                     queue_empty_i,
  input logic [1:0]               status_i
);
  import mq_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(popped_value_i)
      && $stable(max_value_i) && $stable(queue_empty_i) && $stable(status_i))
    else $error("output word changed while stalled");

  a_empty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && queue_empty_i |-> max_value_i == '0)
    else $error("empty queue reports nonzero max");

  a_err_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != 2'(ST_OK)) |-> popped_value_i == '0)
    else $error("failed operation returns a popped value");

  a_err_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((status_i == 2'(ST_POP_EMPTY)) && !queue_empty_i
      || (status_i == 2'(ST_PUSH_FULL)) && queue_empty_i) |-> 1'b0)
    else $error("status disagrees with empty flag");

endmodule

bind fifo_with_running_max mq_chk u_mq_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .popped_value_i (out_o.popped_value),
  .max_value_i    (out_o.max_value),
  .queue_empty_i  (out_o.queue_empty),
  .status_i       (out_o.status)
);

// ===== tb/tb_fifo_with_running_max.sv =====
`timescale 1ns / 1ps

module tb_fifo_with_running_max;
  import mq_pkg::*;

  localparam int unsigned TOTAL_WORDS = 1550;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = DEPTH + 8;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  // Mirror of the queue: ring contents, front position, fill level and maximum.
  class max_queue_tracker;
    logic [VAL_W-1:0] ring [DEPTH];
    int unsigned      head;
    int unsigned      count;
    logic [VAL_W-1:0] top;
    res_t             pending_outcomes[$];
    int unsigned      mismatches;

    function new();
      head       = 0;
      count      = 0;
      top        = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction

    function logic [VAL_W-1:0] rescan_top();
      logic [VAL_W-1:0] best;
      best = '0;
      for (int unsigned k = 0; k < count; k++) begin
        if (ring[(head + k) % DEPTH] > best) begin
          best = ring[(head + k) % DEPTH];
        end
      end
      return best;
    endfunction

    function void note_word(op_e op, logic [VAL_W-1:0] val);
      res_t r;
      r        = '0;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
        if (count >= DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else begin
          ring[(head + count) % DEPTH] = val;
          count++;
          if (val > top) begin
            top = val;
          end
        end
      end else begin
        if (count == 0) begin
          r.status = ST_POP_EMPTY;
        end else begin
          r.popped_value = ring[head];
          head = (head + 1) % DEPTH;
          count--;
          if (count == 0) begin
            top = '0;
          end else if (r.popped_value == top) begin
            top = rescan_top();
          end
        end
      end
      r.max_value   = top;
      r.queue_empty = (count == 0);
      pending_outcomes.push_back(r);
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.popped_value !== want.popped_value) begin
        $display("%0t: popped_value expected %0d actual %0d",
                 $time, want.popped_value, got.popped_value);
        mismatches++;
      end
      if (got.max_value !== want.max_value) begin
        $display("%0t: max_value expected %0d actual %0d",
                 $time, want.max_value, got.max_value);
        mismatches++;
      end
      if (got.queue_empty !== want.queue_empty) begin
        $display("%0t: queue_empty expected %0b actual %0b",
                 $time, want.queue_empty, got.queue_empty);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d",
                 $time, want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mq_in_if  in_if ();
  mq_out_if out_if ();

  fifo_with_running_max u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  max_queue_tracker sb = new();
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 88) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  // Mix of wide values, small values that repeat the maximum, and extremes.
  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return VAL_W'($urandom());
      4, 5:       return VAL_W'($urandom_range(7));
      6:          return '0;
      7:          return VAL_MAX;
      8:          return VAL_MAX - VAL_W'($urandom_range(15));
      default:    return VAL_W'(1) << $urandom_range(VAL_W - 1);
    endcase
  endfunction

  task automatic send_word(input op_e op, input logic [VAL_W-1:0] val,
                           input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= val;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    words_sent++;
  endtask

  // Hold off the sender until every outstanding result has drained.
  task automatic settle_queue();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        sb.note_word(op_e'(in_if.operation), in_if.value);
      end
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        sb.check_word('{popped_value: out_if.popped_value,
                        max_value:    out_if.max_value,
                        queue_empty:  out_if.queue_empty,
                        status:       status_e'(out_if.status)});
      end
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb_fifo_with_running_max NOT OK");
        $finish;
      end
    end
  end

  initial begin : drain_side
    int unsigned stall_left;
    int unsigned mode_left;
    bit          steady;
    stall_left   = 0;
    mode_left    = 0;
    steady       = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        steady    = ($urandom_range(3) == 0);
        mode_left = $urandom_range(300, 50);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!steady && $urandom_range(2) == 0) begin
        stall_left = pick_gap();
      end
      out_if.ready <= (stall_left == 0);
    end
  end

  initial begin : stimulus
    int unsigned burst_len;
    int unsigned push_pct;
    bit          steady;
    op_e         op;
    in_if.valid     = 1'b0;
    in_if.operation = OP_PUSH;
    in_if.value     = '0;
    rst_ni          = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty pop, last-entry pop, max removal with rescan, duplicate maxima.
    send_word(OP_POP,  VAL_MAX,          pick_gap());
    send_word(OP_PUSH, '0,               pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    send_word(OP_PUSH, VAL_MAX,          pick_gap());
    send_word(OP_PUSH, '0,               pick_gap());
    send_word(OP_PUSH, VAL_W'(5),        pick_gap());
    send_word(OP_PUSH, VAL_W'(5),        pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    send_word(OP_POP,  VAL_MAX,          pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    send_word(OP_PUSH, VAL_W'(1) << 30,  pick_gap());
    send_word(OP_PUSH, VAL_W'(1),        pick_gap());
    send_word(OP_PUSH, VAL_W'(2),        pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    send_word(OP_POP,  '0,               pick_gap());
    settle_queue();

    // Run past full, then past empty.
    repeat (DEPTH + 3) send_word(OP_PUSH, draw_value(), pick_gap());
    repeat (DEPTH + 3) send_word(OP_POP,  draw_value(), pick_gap());

    while (words_sent < TOTAL_WORDS) begin
      burst_len = $urandom_range(120, 20);
      case ($urandom_range(3))
        0:       push_pct = 90;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = 65;
      endcase
      steady = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) begin
        settle_queue();
      end
      repeat (burst_len) begin
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        send_word(op, draw_value(), steady ? 0 : pick_gap());
      end
    end

    settle_queue();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_fifo_with_running_max OK");
    end else begin
      $display("tb_fifo_with_running_max NOT OK");
    end
    $finish;
  end

endmodule
